// ----- src/plt_pkg.sv -----
package plt_pkg;

  localparam int DATA_W = 32;
  localparam int CMD_W  = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_GET    = 3'd2,
    CMD_PRIOR  = 3'd3,
    CMD_NEXT   = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE,
    OP_ROTATE
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH
  } state_e;

endpackage

// ----- src/positional_list_table.sv -----
// Insert, clear and unknown commands: result registered at the transfer edge, offered in the next cycle.
// Delete, get, prior and next: the ring of cells rotates CAPACITY times past the head
// cell, then a finishing state registers the result once the output register is free.
// Throughput: one insert or clear per cycle while the output is not held; no new command is taken during a sweep.
// Reset (asynchronous, active low) empties the list; entry cells hold no reset value.
module positional_list_table #(
  parameter int CAPACITY = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [plt_pkg::CMD_W-1:0]          command_i,
  input  logic [$clog2(CAPACITY+1)-1:0]      position_i,
  input  logic signed [plt_pkg::DATA_W-1:0]  value_in_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               ok_o,
  output logic signed [plt_pkg::DATA_W-1:0]  value_out_o,
  output logic [$clog2(CAPACITY+1)-1:0]      count_o
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY+1);
  localparam int DW    = plt_pkg::DATA_W;

  logic [DW-1:0] entry [CAPACITY];

  plt_pkg::state_e   state_q, state_d;
  plt_pkg::cell_op_e cell_op;
  logic [IDX_W-1:0]  cell_sel;

  logic [IDX_W-1:0]  k_q, k_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic              out_valid_q, out_valid_d;
  logic              out_ok_q, out_ok_d;
  logic [DW-1:0]     out_value_q, out_value_d;
  logic [CNT_W-1:0]  out_count_q, out_count_d;

  plt_pkg::cmd_e     cmd_q, cmd_d;
  logic [CNT_W-1:0]  pos_q, pos_d;
  logic [DW-1:0]     val_q, val_d;
  logic [DW-1:0]     res_q, res_d;
  logic              ok_q, ok_d;
  logic              found_q, found_d;

  plt_pkg::cmd_e     cmd_in;
  logic              out_free, accept, sweep_cmd, ins_ok;
  logic [CNT_W-1:0]  k_ext;
  logic              in_list;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    plt_cell #(
      .IDX_W (IDX_W),
      .IDX   (i)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op),
      .sel_i   (cell_sel),
      .value_i (value_in_i),
      .left_i  ((i == 0) ? value_in_i : entry[(i + CAPACITY - 1) % CAPACITY]),
      .right_i (entry[(i + 1) % CAPACITY]),
      .entry_o (entry[i])
    );
  end

  assign cmd_in    = plt_pkg::cmd_e'(command_i);
  assign out_free  = !out_valid_q || out_ready_i;
  assign accept    = in_valid_i && in_ready_o;
  assign sweep_cmd = (cmd_in == plt_pkg::CMD_DELETE) || (cmd_in == plt_pkg::CMD_GET) ||
                     (cmd_in == plt_pkg::CMD_PRIOR)  || (cmd_in == plt_pkg::CMD_NEXT);
  assign ins_ok    = (position_i != '0) && (fill_q != CNT_W'(CAPACITY)) &&
                     (position_i <= fill_q + CNT_W'(1));
  assign k_ext     = CNT_W'(k_q);
  assign in_list   = k_ext < fill_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      plt_pkg::ST_IDLE: begin
        if (accept && sweep_cmd) begin
          state_d = plt_pkg::ST_SWEEP;
        end
      end
      plt_pkg::ST_SWEEP: begin
        if (k_q == IDX_W'(CAPACITY - 1)) begin
          state_d = plt_pkg::ST_FINISH;
        end
      end
      plt_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = plt_pkg::ST_IDLE;
        end
      end
      default: state_d = plt_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_o = 1'b0;
    cell_op    = plt_pkg::OP_HOLD;
    cell_sel   = IDX_W'(pos_q - CNT_W'(1));
    case (state_q)
      plt_pkg::ST_IDLE: begin
        in_ready_o = out_free;
        cell_sel   = IDX_W'(position_i - CNT_W'(1));
        if (in_valid_i && out_free && (cmd_in == plt_pkg::CMD_INSERT) && ins_ok) begin
          cell_op = plt_pkg::OP_INSERT;
        end
      end
      plt_pkg::ST_SWEEP: cell_op = plt_pkg::OP_ROTATE;
      plt_pkg::ST_FINISH: begin
        if (out_free && (cmd_q == plt_pkg::CMD_DELETE) && ok_q) begin
          cell_op = plt_pkg::OP_DELETE;
        end
      end
      default: cell_op = plt_pkg::OP_HOLD;
    endcase
  end

  // sweep: head cell holds entry k, tail holds entry k-1, cell 1 holds entry k+1
  always_comb begin
    cmd_d   = cmd_q;
    pos_d   = pos_q;
    val_d   = val_q;
    res_d   = res_q;
    ok_d    = ok_q;
    found_d = found_q;
    k_d     = k_q;
    if (state_q == plt_pkg::ST_IDLE) begin
      k_d = '0;
      if (accept) begin
        cmd_d   = cmd_in;
        pos_d   = position_i;
        val_d   = value_in_i;
        res_d   = '0;
        ok_d    = 1'b0;
        found_d = 1'b0;
      end
    end else if (state_q == plt_pkg::ST_SWEEP) begin
      k_d = k_q + IDX_W'(1);
      case (cmd_q)
        plt_pkg::CMD_DELETE, plt_pkg::CMD_GET: begin
          if (in_list && (k_ext + CNT_W'(1) == pos_q)) begin
            ok_d  = 1'b1;
            res_d = entry[0];
          end
        end
        plt_pkg::CMD_PRIOR: begin
          if ((k_q != '0) && in_list && (entry[0] == val_q) && !found_q) begin
            found_d = 1'b1;
            ok_d    = 1'b1;
            res_d   = entry[CAPACITY-1];
          end
        end
        plt_pkg::CMD_NEXT: begin
          if (in_list && (entry[0] == val_q) && !found_q) begin
            found_d = 1'b1;
            if (k_ext + CNT_W'(1) < fill_q) begin
              ok_d  = 1'b1;
              res_d = entry[1];
            end
          end
        end
        default: ok_d = ok_q;
      endcase
    end
  end

  // fill and output register
  always_comb begin
    fill_d      = fill_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_ok_d    = out_ok_q;
    out_value_d = out_value_q;
    out_count_d = out_count_q;
    if (accept && !sweep_cmd) begin
      out_ok_d = 1'b0;
      case (cmd_in)
        plt_pkg::CMD_INSERT: begin
          if (ins_ok) begin
            fill_d   = fill_q + CNT_W'(1);
            out_ok_d = 1'b1;
          end
        end
        plt_pkg::CMD_CLEAR: begin
          fill_d   = '0;
          out_ok_d = 1'b1;
        end
        default: out_ok_d = 1'b0;
      endcase
      out_valid_d = 1'b1;
      out_value_d = '0;
      out_count_d = fill_d;
    end else if ((state_q == plt_pkg::ST_FINISH) && out_free) begin
      if ((cmd_q == plt_pkg::CMD_DELETE) && ok_q) begin
        fill_d = fill_q - CNT_W'(1);
      end
      out_valid_d = 1'b1;
      out_ok_d    = ok_q;
      out_value_d = res_q;
      out_count_d = fill_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= plt_pkg::ST_IDLE;
      k_q         <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
      ok_q        <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      ok_q        <= ok_d;
      found_q     <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    pos_q       <= pos_d;
    val_q       <= val_d;
    res_q       <= res_d;
    out_ok_q    <= out_ok_d;
    out_value_q <= out_value_d;
    out_count_q <= out_count_d;
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = out_ok_q;
  assign value_out_o = out_value_q;
  assign count_o     = out_count_q;

endmodule

// ----- src/plt_cell.sv -----
module plt_cell #(
  parameter int IDX_W = 6,
  parameter int IDX   = 0
) (
  input  logic                          clk_i,
  input  plt_pkg::cell_op_e             op_i,
  input  logic [IDX_W-1:0]              sel_i,
  input  logic [plt_pkg::DATA_W-1:0]    value_i,
  input  logic [plt_pkg::DATA_W-1:0]    left_i,
  input  logic [plt_pkg::DATA_W-1:0]    right_i,
  output logic [plt_pkg::DATA_W-1:0]    entry_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(IDX);

  logic [plt_pkg::DATA_W-1:0] entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    case (op_i)
      plt_pkg::OP_INSERT: begin
        if (MyIdx == sel_i) begin
          entry_d = value_i;
        end else if (MyIdx > sel_i) begin
          entry_d = left_i;
        end
      end
      plt_pkg::OP_DELETE: begin
        if (MyIdx >= sel_i) begin
          entry_d = right_i;
        end
      end
      plt_pkg::OP_ROTATE: entry_d = right_i;
      default:            entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
